// ===== src/pbls_pkg.sv =====
// Package for the power and lock button sequencer.
// Holds item, result, state and register types, event codes and reset values.
// No dependencies.
package pbls_pkg;

   localparam int TimerWidth = 16;

   // Event codes
   localparam logic [2:0] OP_POWER_DOWN   = 3'd0;
   localparam logic [2:0] OP_POWER_UP     = 3'd1;
   localparam logic [2:0] OP_LOCK_DOWN    = 3'd2;
   localparam logic [2:0] OP_LOCK_UP      = 3'd3;
   localparam logic [2:0] OP_SCREEN_LOCKED = 3'd4;
   localparam logic [2:0] OP_TICK         = 3'd5;

   // Register indexes
   localparam logic [2:0] CSR_LOCK_HOLD_TICKS        = 3'd0;
   localparam logic [2:0] CSR_SHUTDOWN_HOLD_TICKS    = 3'd1;
   localparam logic [2:0] CSR_LOCK_TO_SHUTDOWN_TICKS = 3'd2;
   localparam logic [2:0] CSR_ANIMATION_TICKS        = 3'd3;
   localparam logic [2:0] CSR_LEGACY_MODE            = 3'd4;

   // Register reset values
   localparam logic [TimerWidth-1:0] LOCK_HOLD_RESET        = 16'd400;
   localparam logic [TimerWidth-1:0] SHUTDOWN_HOLD_RESET    = 16'd400;
   localparam logic [TimerWidth-1:0] LOCK_TO_SHUTDOWN_RESET = 16'd600;
   localparam logic [TimerWidth-1:0] ANIMATION_RESET        = 16'd150;

   typedef struct packed {
      logic [2:0] op;
      logic       logged_in;
      logic       screen_locked;
      logic       recent_lock_request;
   } pbls_req_type;

   typedef struct packed {
      logic note_pre_lock;
      logic note_aborted_lock;
      logic note_pre_shutdown;
      logic note_aborted_shutdown;
      logic note_shutting_down;
      logic want_lock;
      logic want_brighten;
      logic want_dim;
      logic want_shutdown;
   } pbls_rsp_type;

   typedef struct packed {
      logic [TimerWidth-1:0] lock_hold_ticks;
      logic [TimerWidth-1:0] shutdown_hold_ticks;
      logic [TimerWidth-1:0] lock_to_shutdown_ticks;
      logic [TimerWidth-1:0] animation_ticks;
      logic                  legacy_mode;
   } pbls_cfg_type;

   typedef struct packed {
      logic                  power_held;
      logic                  lock_held;
      logic                  going_down;
      logic                  await_lock;
      logic [TimerWidth-1:0] lock_timer;
      logic [TimerWidth-1:0] lock_to_shut_timer;
      logic [TimerWidth-1:0] lock_fail_timer;
      logic [TimerWidth-1:0] shut_timer;
      logic [TimerWidth-1:0] anim_timer;
   } pbls_state_type;

   // A duration of zero runs as one tick
   function automatic logic [TimerWidth-1:0] dur(input logic [TimerWidth-1:0] v);
      dur = (v == '0) ? TimerWidth'(1) : v;
   endfunction

endpackage

// ===== src/pbls_step.sv =====
// Next-state and result logic for one item of the button sequencer.
// Purely combinational; depends on pbls_pkg.
module pbls_step (
   input  pbls_pkg::pbls_req_type   req,
   input  pbls_pkg::pbls_cfg_type   cfg,
   input  pbls_pkg::pbls_state_type cur,
   output pbls_pkg::pbls_state_type nxt,
   output pbls_pkg::pbls_rsp_type   rsp
);
   import pbls_pkg::*;

   logic may_lock;
   logic f_lock;
   logic f_l2s;
   logic f_fail;
   logic f_shut;
   logic f_anim;

   always_comb begin
      nxt      = cur;
      rsp      = '0;
      may_lock = req.logged_in & ~req.screen_locked;
      f_lock   = 1'b0;
      f_l2s    = 1'b0;
      f_fail   = 1'b0;
      f_shut   = 1'b0;
      f_anim   = 1'b0;
      unique case (req.op)
         OP_POWER_DOWN: begin
            if (!cur.going_down) begin
               nxt.power_held = 1'b1;
               if (cfg.legacy_mode) begin
                  if (may_lock) begin
                     rsp.want_lock = 1'b1;
                  end else begin
                     nxt.shut_timer         = '0;
                     nxt.going_down         = 1'b1;
                     rsp.note_shutting_down = 1'b1;
                     nxt.anim_timer         = dur(cfg.animation_ticks);
                  end
               end else if (req.recent_lock_request && !req.screen_locked) begin
                  nxt.await_lock = 1'b1;
               end else if (may_lock) begin
                  rsp.note_pre_lock = 1'b1;
                  nxt.lock_timer    = dur(cfg.lock_hold_ticks);
               end else begin
                  rsp.note_pre_shutdown = 1'b1;
                  nxt.shut_timer        = dur(cfg.shutdown_hold_ticks);
               end
            end
         end
         OP_POWER_UP: begin
            if (!cur.going_down) begin
               nxt.power_held = 1'b0;
               nxt.await_lock = 1'b0;
               if (!cfg.legacy_mode) begin
                  if (cur.lock_timer != '0) begin
                     nxt.lock_timer        = '0;
                     rsp.note_aborted_lock = 1'b1;
                  end
                  if (cur.shut_timer != '0) begin
                     nxt.shut_timer            = '0;
                     rsp.note_aborted_shutdown = 1'b1;
                  end
                  nxt.lock_to_shut_timer = '0;
                  nxt.lock_fail_timer    = '0;
               end
            end
         end
         OP_LOCK_DOWN: begin
            if (!cur.going_down) begin
               nxt.lock_held = 1'b1;
               if (may_lock) begin
                  rsp.note_pre_lock = 1'b1;
                  nxt.lock_timer    = dur(cfg.lock_hold_ticks);
               end
            end
         end
         OP_LOCK_UP: begin
            if (!cur.going_down) begin
               nxt.lock_held = 1'b0;
               if (cur.lock_timer != '0) begin
                  nxt.lock_timer        = '0;
                  rsp.note_aborted_lock = 1'b1;
               end
            end
         end
         OP_SCREEN_LOCKED: begin
            if (cur.await_lock) begin
               nxt.await_lock        = 1'b0;
               nxt.lock_fail_timer   = '0;
               rsp.note_pre_shutdown = 1'b1;
               nxt.shut_timer        = dur(cfg.shutdown_hold_ticks);
            end
         end
         OP_TICK: begin
            // Count every running timer down first
            f_lock = (cur.lock_timer == TimerWidth'(1));
            f_l2s  = (cur.lock_to_shut_timer == TimerWidth'(1));
            f_fail = (cur.lock_fail_timer == TimerWidth'(1));
            f_shut = (cur.shut_timer == TimerWidth'(1));
            f_anim = (cur.anim_timer == TimerWidth'(1));
            if (cur.lock_timer != '0) nxt.lock_timer = cur.lock_timer - TimerWidth'(1);
            if (cur.lock_to_shut_timer != '0)
               nxt.lock_to_shut_timer = cur.lock_to_shut_timer - TimerWidth'(1);
            if (cur.lock_fail_timer != '0)
               nxt.lock_fail_timer = cur.lock_fail_timer - TimerWidth'(1);
            if (cur.shut_timer != '0) nxt.shut_timer = cur.shut_timer - TimerWidth'(1);
            if (cur.anim_timer != '0) nxt.anim_timer = cur.anim_timer - TimerWidth'(1);
            // Handle expiries in fixed order; a timer restarted above does not fire
            if (f_lock && nxt.lock_timer == '0) begin
               rsp.want_lock     = 1'b1;
               rsp.want_brighten = 1'b1;
               if (!(cur.lock_held && !cur.power_held))
                  nxt.lock_to_shut_timer = dur(cfg.lock_to_shutdown_ticks);
            end
            if (f_l2s && nxt.lock_to_shut_timer == '0) begin
               if (req.screen_locked) begin
                  rsp.note_pre_shutdown = 1'b1;
                  nxt.shut_timer        = dur(cfg.shutdown_hold_ticks);
               end else begin
                  nxt.await_lock      = 1'b1;
                  nxt.lock_fail_timer = dur(cfg.shutdown_hold_ticks);
               end
            end
            if (f_fail && nxt.lock_fail_timer == '0) begin
               if (nxt.await_lock && !req.screen_locked) begin
                  nxt.await_lock        = 1'b0;
                  rsp.note_pre_shutdown = 1'b1;
                  nxt.shut_timer        = dur(cfg.shutdown_hold_ticks);
               end
            end
            if (f_shut && nxt.shut_timer == '0) begin
               nxt.shut_timer         = '0;
               nxt.going_down         = 1'b1;
               rsp.note_shutting_down = 1'b1;
               nxt.anim_timer         = dur(cfg.animation_ticks);
            end
            if (f_anim && nxt.anim_timer == '0) begin
               rsp.want_dim      = 1'b1;
               rsp.want_shutdown = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== src/power_button_lock_shutdown_sequencer_unit.sv =====
// Top level of the power and lock button sequencer.
// Holds the input stage, sequencer state, registers and result stage;
// depends on pbls_pkg and pbls_step.

// One event item enters per cycle while req_stall is low. The item is captured
// in an input register, passes once through the step logic, which updates the
// button flags and the five tick timers, and lands in a result register.
// Back-to-back items sustain one per cycle as long as results are taken; a
// stalled result holds the result register and then the input register. Timer
// durations of zero run as one tick. Register writes take effect on the next
// cycle and belong only to an idle block: the user must see to it, as the block does not check.
module power_button_lock_shutdown_sequencer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pbls_pkg::pbls_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pbls_pkg::pbls_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import pbls_pkg::*;

   pbls_req_type   req_ff;
   logic           req_valid_ff;
   logic           req_valid_in;
   pbls_state_type state_ff;
   pbls_state_type state_in;
   pbls_cfg_type   cfg_ff;
   pbls_rsp_type   rsp_ff;
   pbls_rsp_type   rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           advance;
   logic           take;

   pbls_step u_step (
      .req (req_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Advance when the result register is free or being emptied
   assign advance      = req_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = req_valid_ff & ~advance;
   assign take         = req_valid & ~req_stall;
   assign req_valid_in = take | (req_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.lock_hold_ticks        <= LOCK_HOLD_RESET;
         cfg_ff.shutdown_hold_ticks    <= SHUTDOWN_HOLD_RESET;
         cfg_ff.lock_to_shutdown_ticks <= LOCK_TO_SHUTDOWN_RESET;
         cfg_ff.animation_ticks        <= ANIMATION_RESET;
         cfg_ff.legacy_mode            <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOCK_HOLD_TICKS:        cfg_ff.lock_hold_ticks <= csr_wdata;
               CSR_SHUTDOWN_HOLD_TICKS:    cfg_ff.shutdown_hold_ticks <= csr_wdata;
               CSR_LOCK_TO_SHUTDOWN_TICKS: cfg_ff.lock_to_shutdown_ticks <= csr_wdata;
               CSR_ANIMATION_TICKS:        cfg_ff.animation_ticks <= csr_wdata;
               CSR_LEGACY_MODE:            cfg_ff.legacy_mode <= csr_wdata[0];
               default:                    cfg_ff <= cfg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) req_ff <= req_data;
      if (advance) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // Once committed to shutdown, stay committed until reset
   a_going_down_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.going_down |=> state_ff.going_down)
      else $error("going_down dropped without reset");

   // A shutdown request only follows a committed shutdown
   a_shutdown_committed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.want_shutdown |-> state_ff.going_down)
      else $error("shutdown requested while not going down");

   // Dim and shutdown are always raised together
   a_dim_with_shutdown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.want_dim == rsp_data.want_shutdown)
      else $error("dim and shutdown flags disagree");

   // Committing to shutdown leaves the block going down
   a_commit_state: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.note_shutting_down |=> state_ff.going_down)
      else $error("shutting-down note without going_down");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for power_button_lock_shutdown_sequencer_unit.
// Drives button, screen-lock and tick items and predicts every result.
// Depends on pbls_pkg and the RTL under src.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pbls_pkg::*;

   localparam logic [2:0] OP_RESERVED_LO = 3'd6;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;
   localparam logic [2:0] CSR_PAST_END   = 3'd5;
   localparam logic [2:0] CSR_LAST_INDEX = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pbls_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pbls_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   // Shadow of the sequencer and its registers
   pbls_state_type sequencer;
   pbls_cfg_type   regs;
   pbls_rsp_type   flags;
   pbls_rsp_type   pending_flags[$];
   int             mismatches = 0;
   logic           steady = 1'b0;

   power_button_lock_shutdown_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 15);
   end

   function automatic logic [15:0] hold_len(input logic [15:0] v);
      return (v == '0) ? 16'd1 : v;
   endfunction

   function automatic void begin_shutdown_hold();
      flags.note_pre_shutdown = 1'b1;
      sequencer.shut_timer = hold_len(regs.shutdown_hold_ticks);
   endfunction

   function automatic void commit_shutdown();
      sequencer.shut_timer = '0;
      sequencer.going_down = 1'b1;
      flags.note_shutting_down = 1'b1;
      sequencer.anim_timer = hold_len(regs.animation_ticks);
   endfunction

   // Advance the shadow by one item and return the flags it raises
   function automatic pbls_rsp_type step_sequencer(input pbls_req_type item);
      logic may_lock, fire_lock, fire_l2s, fire_fail, fire_shut, fire_anim;
      flags = '0;
      may_lock = item.logged_in && !item.screen_locked;
      if (!(sequencer.going_down && item.op <= OP_LOCK_UP)) begin
         case (item.op)
            OP_POWER_DOWN: begin
               sequencer.power_held = 1'b1;
               if (regs.legacy_mode) begin
                  if (may_lock) flags.want_lock = 1'b1;
                  else commit_shutdown();
               end else if (item.recent_lock_request && !item.screen_locked) begin
                  sequencer.await_lock = 1'b1;
               end else if (may_lock) begin
                  flags.note_pre_lock = 1'b1;
                  sequencer.lock_timer = hold_len(regs.lock_hold_ticks);
               end else begin
                  begin_shutdown_hold();
               end
            end
            OP_POWER_UP: begin
               sequencer.power_held = 1'b0;
               sequencer.await_lock = 1'b0;
               if (!regs.legacy_mode) begin
                  if (sequencer.lock_timer != '0) begin
                     sequencer.lock_timer = '0;
                     flags.note_aborted_lock = 1'b1;
                  end
                  if (sequencer.shut_timer != '0) begin
                     sequencer.shut_timer = '0;
                     flags.note_aborted_shutdown = 1'b1;
                  end
                  sequencer.lock_to_shut_timer = '0;
                  sequencer.lock_fail_timer = '0;
               end
            end
            OP_LOCK_DOWN: begin
               sequencer.lock_held = 1'b1;
               if (may_lock) begin
                  flags.note_pre_lock = 1'b1;
                  sequencer.lock_timer = hold_len(regs.lock_hold_ticks);
               end
            end
            OP_LOCK_UP: begin
               sequencer.lock_held = 1'b0;
               if (sequencer.lock_timer != '0) begin
                  sequencer.lock_timer = '0;
                  flags.note_aborted_lock = 1'b1;
               end
            end
            OP_SCREEN_LOCKED: begin
               if (sequencer.await_lock) begin
                  sequencer.await_lock = 1'b0;
                  sequencer.lock_fail_timer = '0;
                  begin_shutdown_hold();
               end
            end
            OP_TICK: begin
               fire_lock = sequencer.lock_timer == 16'd1;
               fire_l2s  = sequencer.lock_to_shut_timer == 16'd1;
               fire_fail = sequencer.lock_fail_timer == 16'd1;
               fire_shut = sequencer.shut_timer == 16'd1;
               fire_anim = sequencer.anim_timer == 16'd1;
               sequencer.lock_timer -= 16'(sequencer.lock_timer != '0);
               sequencer.lock_to_shut_timer -= 16'(sequencer.lock_to_shut_timer != '0);
               sequencer.lock_fail_timer -= 16'(sequencer.lock_fail_timer != '0);
               sequencer.shut_timer -= 16'(sequencer.shut_timer != '0);
               sequencer.anim_timer -= 16'(sequencer.anim_timer != '0);
               // Handle expiries in fixed order; a restarted timer does not fire
               if (fire_lock && sequencer.lock_timer == '0) begin
                  flags.want_lock = 1'b1;
                  flags.want_brighten = 1'b1;
                  if (!(sequencer.lock_held && !sequencer.power_held))
                     sequencer.lock_to_shut_timer = hold_len(regs.lock_to_shutdown_ticks);
               end
               if (fire_l2s && sequencer.lock_to_shut_timer == '0) begin
                  if (item.screen_locked) begin
                     begin_shutdown_hold();
                  end else begin
                     sequencer.await_lock = 1'b1;
                     sequencer.lock_fail_timer = hold_len(regs.shutdown_hold_ticks);
                  end
               end
               if (fire_fail && sequencer.lock_fail_timer == '0 &&
                   sequencer.await_lock && !item.screen_locked) begin
                  sequencer.await_lock = 1'b0;
                  begin_shutdown_hold();
               end
               if (fire_shut && sequencer.shut_timer == '0) commit_shutdown();
               if (fire_anim && sequencer.anim_timer == '0) begin
                  flags.want_dim = 1'b1;
                  flags.want_shutdown = 1'b1;
               end
            end
            default: ;
         endcase
      end
      return flags;
   endfunction

   task automatic check_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : take_result
      pbls_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flags.size() == 0) begin
            $error("result arrived with no item pending");
            mismatches++;
         end else begin
            want = pending_flags.pop_front();
            check_flag("note_pre_lock", want.note_pre_lock, rsp_data.note_pre_lock);
            check_flag("note_aborted_lock", want.note_aborted_lock,
                       rsp_data.note_aborted_lock);
            check_flag("note_pre_shutdown", want.note_pre_shutdown,
                       rsp_data.note_pre_shutdown);
            check_flag("note_aborted_shutdown", want.note_aborted_shutdown,
                       rsp_data.note_aborted_shutdown);
            check_flag("note_shutting_down", want.note_shutting_down,
                       rsp_data.note_shutting_down);
            check_flag("want_lock", want.want_lock, rsp_data.want_lock);
            check_flag("want_brighten", want.want_brighten, rsp_data.want_brighten);
            check_flag("want_dim", want.want_dim, rsp_data.want_dim);
            check_flag("want_shutdown", want.want_shutdown, rsp_data.want_shutdown);
         end
      end
   end

   // Offer one item, hold it until taken, then record its expected flags
   task automatic send_item(input pbls_req_type item);
      while (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_flags.push_back(step_sequencer(item));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_LOCK_HOLD_TICKS:        regs.lock_hold_ticks = value;
         CSR_SHUTDOWN_HOLD_TICKS:    regs.shutdown_hold_ticks = value;
         CSR_LOCK_TO_SHUTDOWN_TICKS: regs.lock_to_shutdown_ticks = value;
         CSR_ANIMATION_TICKS:        regs.animation_ticks = value;
         CSR_LEGACY_MODE:            regs.legacy_mode = value[0];
         default: ;
      endcase
   endtask

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic pbls_req_type event_of(input logic [2:0] op, input logic logged,
                                             input logic locked, input logic recent);
      pbls_req_type item;
      item.op = op;
      item.logged_in = logged;
      item.screen_locked = locked;
      item.recent_lock_request = recent;
      return item;
   endfunction

   function automatic logic [15:0] short_hold();
      if ($urandom_range(9) == 0) return '0;
      return 16'($urandom_range(6, 1));
   endfunction

   // Random walk over the events; guarded keeps the block out of shutdown
   function automatic pbls_req_type random_event(input logic guarded);
      pbls_req_type item;
      int unsigned  pick;
      pick = $urandom_range(99);
      item.logged_in = $urandom_range(99) < 80;
      item.screen_locked = $urandom_range(99) < 30;
      item.recent_lock_request = $urandom_range(99) < 20;
      if (pick < 48) item.op = OP_TICK;
      else if (pick < 58) item.op = OP_POWER_DOWN;
      else if (pick < 66) item.op = OP_POWER_UP;
      else if (pick < 75) item.op = OP_LOCK_DOWN;
      else if (pick < 84) item.op = OP_LOCK_UP;
      else if (pick < 95) item.op = OP_SCREEN_LOCKED;
      else item.op = pick[0] ? OP_RESERVED_HI : OP_RESERVED_LO;
      if (guarded) begin
         if (item.op == OP_TICK && sequencer.shut_timer == 16'd1)
            item.op = regs.legacy_mode ? OP_LOCK_UP : OP_POWER_UP;
         if (item.op == OP_POWER_DOWN && regs.legacy_mode) begin
            item.logged_in = 1'b1;
            item.screen_locked = 1'b0;
         end
      end
      return item;
   endfunction

   // Release both buttons in normal mode to clear the holds, then reload
   task automatic load_settings(input logic [15:0] lock_hold, shut_hold, to_shut, anim,
                                input logic legacy);
      wait_idle();
      write_reg(CSR_LEGACY_MODE, '0);
      send_item(event_of(OP_POWER_UP, coin(), coin(), coin()));
      send_item(event_of(OP_LOCK_UP, coin(), coin(), coin()));
      wait_idle();
      write_reg(CSR_LOCK_HOLD_TICKS, lock_hold);
      write_reg(CSR_SHUTDOWN_HOLD_TICKS, shut_hold);
      write_reg(CSR_LOCK_TO_SHUTDOWN_TICKS, to_shut);
      write_reg(CSR_ANIMATION_TICKS, anim);
      write_reg(CSR_LEGACY_MODE, 16'(legacy));
   endtask

   task automatic run_phase(input logic [15:0] lock_hold, shut_hold, to_shut, anim,
                            input logic legacy, input int count);
      load_settings(lock_hold, shut_hold, to_shut, anim, legacy);
      repeat (count) send_item(random_event(1'b1));
   endtask

   task automatic test_button_holds();
      send_item(event_of(OP_POWER_DOWN, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_POWER_UP, 1'b1, 1'b1, 1'b1));
      send_item(event_of(OP_LOCK_DOWN, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_LOCK_UP, 1'b0, 1'b0, 1'b0));
      send_item(event_of(OP_POWER_DOWN, 1'b1, 1'b0, 1'b1));
      send_item(event_of(OP_SCREEN_LOCKED, 1'b1, 1'b1, 1'b0));
      send_item(event_of(OP_POWER_UP, 1'b0, 1'b0, 1'b0));
      send_item(event_of(OP_POWER_DOWN, 1'b0, 1'b1, 1'b0));
      send_item(event_of(OP_POWER_UP, 1'b1, 1'b0, 1'b1));
      send_item(event_of(OP_RESERVED_LO, 1'b1, 1'b1, 1'b1));
      send_item(event_of(OP_RESERVED_HI, 1'b0, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b1, 1'b1));
   endtask

   // Zero durations run as one tick; a write past the last register is dropped
   task automatic test_zero_durations();
      wait_idle();
      write_reg(CSR_LOCK_HOLD_TICKS, '0);
      write_reg(CSR_SHUTDOWN_HOLD_TICKS, '0);
      write_reg(CSR_LOCK_TO_SHUTDOWN_TICKS, '0);
      write_reg(CSR_ANIMATION_TICKS, '0);
      write_reg(3'($urandom_range(CSR_LAST_INDEX, CSR_PAST_END)), 16'hFFFF);
      send_item(event_of(OP_POWER_DOWN, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b0, 1'b0, 1'b1));
      send_item(event_of(OP_POWER_UP, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_LOCK_DOWN, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_LOCK_UP, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_POWER_DOWN, 1'b1, 1'b0, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b1, 1'b0));
      send_item(event_of(OP_TICK, 1'b1, 1'b1, 1'b0));
      send_item(event_of(OP_POWER_UP, 1'b1, 1'b1, 1'b0));
   endtask

   task automatic test_random_holds();
      run_phase(16'd1, 16'd1, 16'd1, 16'd1, 1'b0, 200);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 60);
      steady = 1'b1;
      run_phase(short_hold(), short_hold(), short_hold(), short_hold(), 1'b0, 200);
      steady = 1'b0;
      repeat (3)
         run_phase(short_hold(), short_hold(), short_hold(), short_hold(), 1'b0, 250);
   endtask

   task automatic test_legacy_mode();
      run_phase(short_hold(), short_hold(), short_hold(), short_hold(), 1'b1, 200);
      run_phase(16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 150);
   endtask

   // Commit to shutdown once, by a press in legacy mode or by the hold running out
   task automatic test_shutdown();
      logic via_legacy;
      via_legacy = coin();
      load_settings(16'($urandom_range(4, 1)), 16'($urandom_range(3)),
                    16'($urandom_range(4, 1)), 16'($urandom_range(6)), via_legacy);
      send_item(event_of(OP_POWER_DOWN, 1'b0, coin(), 1'b0));
      while (!sequencer.going_down)
         send_item(event_of(OP_TICK, coin(), coin(), coin()));
      repeat (150) send_item(random_event(1'b0));
   endtask

   initial begin
      sequencer = '0;
      regs = {LOCK_HOLD_RESET, SHUTDOWN_HOLD_RESET, LOCK_TO_SHUTDOWN_RESET,
              ANIMATION_RESET, 1'b0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_button_holds();
      test_zero_durations();
      test_random_holds();
      test_legacy_mode();
      test_shutdown();
      wait_idle();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
